>>> rtl/lz4d_pkg.sv
// lz4d_pkg: shared types and constants of the lz4 block decoder
// used by lz4d_parser and lz4_block_decoder_core; depends on nothing else
package lz4d_pkg;

    // parser phases, one-hot
    typedef enum logic [7:0] {
        PH_TOKEN     = 8'b0000_0001,
        PH_LIT_EXT   = 8'b0000_0010,
        PH_LITERALS  = 8'b0000_0100,
        PH_OFF_LO    = 8'b0000_1000,
        PH_OFF_HI    = 8'b0001_0000,
        PH_MATCH_EXT = 8'b0010_0000,
        PH_COPY      = 8'b0100_0000,
        PH_DISCARD   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BUSY       = 2'd1,
        ST_BAD_OFFSET = 2'd2
    } status_t;

    // command carried in s_tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [3:0] NIBBLE_EXT = 4'hF;
    localparam logic [7:0] BYTE_EXT   = 8'hFF;
    localparam logic [2:0] MATCH_MIN  = 3'd4;
    localparam int         OFF_W      = 16;

    // what the parser decided for one accepted transfer
    typedef struct packed {
        logic    prod;      // a decoded byte is produced and enters the ring
        logic    from_mem;  // byte comes from the history ring
        logic [7:0] lit;    // literal byte, zero otherwise
        status_t status;
        logic    done;
    } step_t;

    // one result held in the output queue
    typedef struct packed {
        logic    valid;
        logic [7:0] data;
        status_t status;
        logic    done;
    } res_t;

endpackage

>>> rtl/lz4d_parser.sv
// lz4d_parser: token, length, offset and copy bookkeeping of the lz4 block decoder
// updates its state on every accepted transfer; depends on lz4d_pkg
module lz4d_parser import lz4d_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int LENGTH_BITS   = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic                             cmd,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    output step_t                            step,
    output logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
    output logic [$clog2(HISTORY_DEPTH)-1:0] raddr
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int PCW = $clog2(HISTORY_DEPTH + 1);
    localparam int XW  = OFF_W + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             nib_reg, nib_next;
    logic [LENGTH_BITS-1:0] lit_reg, lit_next;
    logic [LENGTH_BITS-1:0] mrem_reg, mrem_next;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [PCW-1:0]         pc_reg, pc_next;
    logic                   end_reg, end_next;

    logic [LENGTH_BITS-1:0] mlen;
    logic [OFF_W-1:0]       off_full;
    logic [XW-1:0]          wp_x;
    logic [XW-1:0]          off_x;
    logic                   last_eff;
    logic                   push;

    function automatic logic [LENGTH_BITS-1:0] sat_add(
        input logic [LENGTH_BITS-1:0] a,
        input logic [7:0]             b
    );
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + (LENGTH_BITS + 1)'(b);
        return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
    endfunction

    // ring address at distance offset behind the write pointer
    assign wp_x  = XW'(wp_reg);
    assign off_x = XW'(off_reg);
    always_comb begin
        if (wp_x >= off_x) begin
            raddr = AW'(wp_x - off_x);
        end else begin
            raddr = AW'(wp_x + XW'(HISTORY_DEPTH) - off_x);
        end
    end
    assign waddr = wp_reg;

    always_comb begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        lit_next   = lit_reg;
        mrem_next  = mrem_reg;
        off_next   = off_reg;
        wp_next    = wp_reg;
        pc_next    = pc_reg;
        end_next   = end_reg;
        step       = '0;
        step.status = ST_OK;
        last_eff   = 1'b0;
        push       = 1'b0;
        mlen       = '0;
        off_full   = {in_byte, off_reg[7:0]};

        if (accept) begin
            if (cmd == CMD_TICK) begin
                if (phase_reg == PH_COPY) begin
                    push          = 1'b1;
                    step.from_mem = 1'b1;
                    mlen = (mrem_reg != '0) ? mrem_reg - LENGTH_BITS'(1) : '0;
                    mrem_next = mlen;
                    if (mlen == '0) begin
                        if (end_reg) begin
                            last_eff = 1'b1;
                        end else begin
                            phase_next = PH_TOKEN;
                        end
                    end
                end
            end else if (phase_reg == PH_COPY) begin
                step.status = ST_BUSY;
            end else begin
                last_eff = in_last;
                case (phase_reg)
                    PH_TOKEN: begin
                        nib_next = in_byte[3:0];
                        lit_next = LENGTH_BITS'(in_byte[7:4]);
                        if (in_byte[7:4] == NIBBLE_EXT) begin
                            phase_next = PH_LIT_EXT;
                        end else if (in_byte[7:4] == 4'd0) begin
                            phase_next = PH_OFF_LO;
                        end else begin
                            phase_next = PH_LITERALS;
                        end
                    end
                    PH_LIT_EXT: begin
                        lit_next = sat_add(lit_reg, in_byte);
                        if (in_byte != BYTE_EXT) begin
                            phase_next = PH_LITERALS;
                        end
                    end
                    PH_LITERALS: begin
                        push     = 1'b1;
                        step.lit = in_byte;
                        mlen = (lit_reg != '0) ? lit_reg - LENGTH_BITS'(1) : '0;
                        lit_next = mlen;
                        if (mlen == '0) begin
                            phase_next = PH_OFF_LO;
                        end
                    end
                    PH_OFF_LO: begin
                        off_next   = OFF_W'(in_byte);
                        phase_next = PH_OFF_HI;
                    end
                    PH_OFF_HI: begin
                        off_next = off_full;
                        if (off_full == '0 || XW'(off_full) > XW'(pc_reg)) begin
                            step.status = ST_BAD_OFFSET;
                            phase_next  = PH_DISCARD;
                        end else if (nib_reg == NIBBLE_EXT && !in_last) begin
                            mrem_next  = LENGTH_BITS'(nib_reg);
                            phase_next = PH_MATCH_EXT;
                        end else begin
                            mrem_next  = sat_add(LENGTH_BITS'(nib_reg), 8'(MATCH_MIN));
                            phase_next = PH_COPY;
                            end_next   = in_last;
                            last_eff   = 1'b0;
                        end
                    end
                    PH_MATCH_EXT: begin
                        mlen = sat_add(mrem_reg, in_byte);
                        mrem_next = mlen;
                        if (in_byte != BYTE_EXT || in_last) begin
                            mrem_next  = sat_add(mlen, 8'(MATCH_MIN));
                            phase_next = PH_COPY;
                            end_next   = in_last;
                            last_eff   = 1'b0;
                        end
                    end
                    default: begin
                        step.status = ST_BAD_OFFSET;
                    end
                endcase
            end

            if (push) begin
                step.prod = 1'b1;
                wp_next = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (pc_reg < PCW'(HISTORY_DEPTH)) begin
                    pc_next = pc_reg + PCW'(1);
                end
            end

            // block end: back to a fresh block
            if (last_eff) begin
                step.done  = 1'b1;
                phase_next = PH_TOKEN;
                nib_next   = '0;
                lit_next   = '0;
                mrem_next  = '0;
                pc_next    = '0;
                end_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TOKEN;
            nib_reg   <= '0;
            lit_reg   <= '0;
            mrem_reg  <= '0;
            off_reg   <= '0;
            wp_reg    <= '0;
            pc_reg    <= '0;
            end_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            lit_reg   <= lit_next;
            mrem_reg  <= mrem_next;
            off_reg   <= off_next;
            wp_reg    <= wp_next;
            pc_reg    <= pc_next;
            end_reg   <= end_next;
        end
    end

endmodule

>>> rtl/lz4_block_decoder_core.sv
// lz4_block_decoder_core: lz4 block decoder, one byte or drain tick per transfer
// an accepted transfer is registered into the resolve stage, then queued for output
// throughput: one transfer per cycle while the output queue has room, including
// back-to-back copy ticks at offset 1; 1R1W history ring, newest byte forwarded
// reset: control state, pointers and the output queue clear; the history ring is
// not initialised and needs no clearing pass
module lz4_block_decoder_core import lz4d_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int LENGTH_BITS   = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    input  logic       s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // block_done
    output logic [2:0] m_tuser    // [0] out_valid, [2:1] status
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int QD = 3;

    logic          accept;
    step_t         step;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    // history ring
    logic [7:0]    ring [HISTORY_DEPTH];
    logic [7:0]    rdata_reg;

    // resolve stage
    logic          s2_valid_reg;
    step_t         s2_step_reg;
    logic [AW-1:0] s2_waddr_reg;
    logic          s2_fwd_reg;
    logic [7:0]    s2_fwd_byte_reg;
    logic [7:0]    s2_byte;
    res_t          s2_res;

    // output queue
    res_t          q_mem [QD];
    logic [1:0]    q_wr_reg, q_rd_reg, q_cnt_reg;
    logic [1:0]    q_wr_next, q_rd_next, q_cnt_next;
    logic          pop;
    res_t          head;

    assign accept = s_tvalid && s_tready;

    lz4d_parser #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cmd     (s_tuser),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .step    (step),
        .waddr   (waddr),
        .raddr   (raddr)
    );

    assign s2_byte = !s2_step_reg.from_mem ? s2_step_reg.lit :
                     (s2_fwd_reg ? s2_fwd_byte_reg : rdata_reg);

    always_ff @(posedge aclk) begin
        rdata_reg <= ring[raddr];
        if (s2_valid_reg && s2_step_reg.prod) begin
            ring[s2_waddr_reg] <= s2_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= accept;
        end
        s2_step_reg  <= step;
        s2_waddr_reg <= waddr;
        // the byte being written this cycle is not yet visible to the read port
        s2_fwd_reg      <= step.from_mem && s2_valid_reg && s2_step_reg.prod &&
                           (s2_waddr_reg == raddr);
        s2_fwd_byte_reg <= s2_byte;
    end

    always_comb begin
        s2_res.valid  = s2_step_reg.prod;
        s2_res.data   = s2_byte;
        s2_res.status = s2_step_reg.status;
        s2_res.done   = s2_step_reg.done;
    end

    // room is kept for every transfer still in the resolve stage
    assign s_tready = ({1'b0, q_cnt_reg} + 3'(s2_valid_reg)) < 3'(QD);
    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_mem[q_rd_reg];

    always_comb begin
        q_wr_next  = q_wr_reg;
        q_rd_next  = q_rd_reg;
        q_cnt_next = q_cnt_reg;
        if (s2_valid_reg) begin
            q_wr_next = (q_wr_reg == 2'(QD - 1)) ? 2'd0 : q_wr_reg + 2'd1;
        end
        if (pop) begin
            q_rd_next = (q_rd_reg == 2'(QD - 1)) ? 2'd0 : q_rd_reg + 2'd1;
        end
        if (s2_valid_reg && !pop) begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end else if (!s2_valid_reg && pop) begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
        end
        if (s2_valid_reg) begin
            q_mem[q_wr_reg] <= s2_res;
        end
    end

    assign m_tdata = head.valid ? head.data : 8'd0;
    assign m_tlast = head.done;
    assign m_tuser = {head.status, head.valid};

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s2_valid_reg && !pop && q_cnt_reg == 2'(QD)))
        else $error("output queue overflow");

    a_accept_reaches_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s2_valid_reg)
        else $error("accepted transfer lost before resolve stage");

    a_fwd_only_for_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_fwd_reg) |-> s2_step_reg.from_mem)
        else $error("forwarding flagged for a non-copy transfer");

    a_busy_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_step_reg.status == ST_BUSY) |->
        (!s2_step_reg.prod && !s2_step_reg.done))
        else $error("rejected byte produced output");

    a_queue_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, q_cnt_reg} + 3'(s2_valid_reg)) <= 3'(QD))
        else $error("in-flight transfers exceed queue space");

endmodule
